// File: sv/pid_frequency_controller_unit_defines.svh
// Assertion helpers shared by the controller RTL.
// Both forms assume a clock named clk and an active-low reset named arst_n.
`ifndef PID_FREQUENCY_CONTROLLER_UNIT_DEFINES_SVH
`define PID_FREQUENCY_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PFC_ASSERT(label, prop, msg)
`define PFC_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// File: sv/pfc_pkg.sv
package pfc_pkg;

	// field widths
	localparam int FREQ_W    = 18;
	localparam int ERR_W     = 19;
	localparam int DIFF_W    = 20;
	localparam int GAIN_W    = 24;
	localparam int LIMIT_W   = 23;
	localparam int DRIVE_W   = 24;

	// integrator width, valid from 20 to 48
	localparam int INTEGRAL_WIDTH = 32;

	// product and accumulation widths
	localparam int PROD_P_W  = GAIN_W + ERR_W;
	localparam int PROD_I_W  = GAIN_W + INTEGRAL_WIDTH;
	localparam int PROD_D_W  = GAIN_W + DIFF_W;
	localparam int SUM_W     = PROD_I_W + 2;
	localparam int DRIVE_SHIFT = 8;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd5;

	// register reset values
	localparam logic [FREQ_W-1:0]         RST_REFERENCE = 18'd84385;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_P    = 24'sd6554;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_I    = 24'sd328;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_D    = -24'sd328;
	localparam logic [FREQ_W-1:0]         RST_DEADBAND  = 18'd3;
	localparam logic [LIMIT_W-1:0]        RST_LIMIT     = 23'd65536;

	// control from the pipeline to the integrator stage
	typedef struct packed {
		logic load;
		logic clear;
	} pfc_step_t;

endpackage

// File: sv/pfc_if.sv
interface pfc_in_if;
	logic                        valid;
	logic                        ready;
	logic [pfc_pkg::FREQ_W-1:0]  measured_freq;
	logic                        clear_integral;

	modport source (output valid, output measured_freq, output clear_integral, input ready);
	modport sink   (input valid, input measured_freq, input clear_integral, output ready);
endinterface

interface pfc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [pfc_pkg::DRIVE_W-1:0] drive;
	logic signed [pfc_pkg::ERR_W-1:0]   error_value;
	logic                              clamped;

	modport source (output valid, output drive, output error_value, output clamped, input ready);
	modport sink   (input valid, input drive, input error_value, input clamped, output ready);
endinterface

// File: sv/pfc_integrator.sv
`include "pid_frequency_controller_unit_defines.svh"

module pfc_integrator (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pfc_pkg::pfc_step_t                        step,
	input  logic [pfc_pkg::FREQ_W-1:0]                meas,
	input  logic [pfc_pkg::FREQ_W-1:0]                reference,
	input  logic [pfc_pkg::FREQ_W-1:0]                deadband,
	output logic signed [pfc_pkg::ERR_W-1:0]          e_s2,
	output logic signed [pfc_pkg::DIFF_W-1:0]         d_s2,
	output logic signed [pfc_pkg::INTEGRAL_WIDTH-1:0] integ_s2
);

	localparam int IW = pfc_pkg::INTEGRAL_WIDTH;

	logic signed [IW-1:0]                  integral_q;
	logic signed [pfc_pkg::ERR_W-1:0]      prev_error_q;

	logic signed [pfc_pkg::ERR_W-1:0]      err;
	logic [pfc_pkg::ERR_W-1:0]             mag;
	logic                                  integrate;
	logic signed [IW-1:0]                  base;
	logic signed [IW:0]                    sum_ext;
	logic signed [IW-1:0]                  sum_sat;
	logic signed [IW-1:0]                  integ_next;
	logic signed [pfc_pkg::DIFF_W-1:0]     diff;

	// error and its magnitude; both frequencies are unsigned so the error fits 19 bits
	assign err = $signed({1'b0, reference}) - $signed({1'b0, meas});
	assign mag = err[pfc_pkg::ERR_W-1] ? pfc_pkg::ERR_W'(-err) : pfc_pkg::ERR_W'(err);
	assign integrate = mag > {1'b0, deadband};

	// clear happens before this step's accumulation
	assign base = step.clear ? '0 : integral_q;
	assign sum_ext = {base[IW-1], base}
		+ {{(IW + 1 - pfc_pkg::ERR_W){err[pfc_pkg::ERR_W-1]}}, err};

	// top two bits disagree: saturate toward the sign of the true sum
	always_comb begin
		if (sum_ext[IW] != sum_ext[IW-1]) begin
			sum_sat = sum_ext[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[IW-1:0];
		end
	end

	assign integ_next = integrate ? sum_sat : base;
	assign diff = {err[pfc_pkg::ERR_W-1], err} - {prev_error_q[pfc_pkg::ERR_W-1], prev_error_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_error_q <= '0;
		end else if (step.load) begin
			integral_q   <= integ_next;
			prev_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (step.load) begin
			e_s2     <= err;
			d_s2     <= diff;
			integ_s2 <= integ_next;
		end
	end

	`PFC_ASSERT_IMP(a_clear_zeroes, $past(step.load && step.clear && !integrate), integral_q == '0, "integral not zero after clear inside deadband")
	`PFC_ASSERT_IMP(a_integral_hold, !$past(step.load), $stable(integral_q), "integral changed without a step")
	`PFC_ASSERT_IMP(a_prev_error_hold, !$past(step.load), $stable(prev_error_q), "previous error changed without a step")

endmodule

// File: sv/pid_frequency_controller_unit.sv
// PID frequency controller.
// sample channel (valid/ready): one measured frequency, unsigned Q10.8, and a
// clear_integral flag that zeroes the integral before the step. Each request
// produces exactly one request on the result channel: the clamped drive (signed
// Q.16), the error reference minus measured (signed Q10.8), and a clamp flag.
// Configuration is a write-only port: cfg_wr_en, cfg_index, cfg_wdata. Indexes
// 0..5 select reference, gain_p, gain_i, gain_d, deadband and drive_limit;
// other indexes are dropped. Write only while the pipeline is empty.
// Throughput: one request per cycle while results are taken; the integrator
// feedback closes within stage 2, so consecutive samples need no spacing.
// Stages: s1 input register, s2 error/deadband/saturating integral, s3 three
// gain multipliers, s4 sum, floor shift by 8, clamp into the output register.
// Reset clears integral, previous error and all valid bits, and loads the
// default configuration. A stalled result holds its stage; earlier stages
// keep filling bubbles, and sample.ready drops only when all four are full.
`include "pid_frequency_controller_unit_defines.svh"

module pid_frequency_controller_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	pfc_in_if.sink                            sample,
	pfc_out_if.source                         result,
	input  logic                              cfg_wr_en,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// configuration registers
	logic [pfc_pkg::FREQ_W-1:0]         reference_q;
	logic signed [pfc_pkg::GAIN_W-1:0]  gain_p_q;
	logic signed [pfc_pkg::GAIN_W-1:0]  gain_i_q;
	logic signed [pfc_pkg::GAIN_W-1:0]  gain_d_q;
	logic [pfc_pkg::FREQ_W-1:0]         deadband_q;
	logic [pfc_pkg::LIMIT_W-1:0]        limit_q;

	// pipeline valids and stage enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// s1
	logic [pfc_pkg::FREQ_W-1:0] meas_s1;
	logic                       clr_s1;

	// s2 (inside the integrator)
	pfc_pkg::pfc_step_t                        step;
	logic signed [pfc_pkg::ERR_W-1:0]          e_s2;
	logic signed [pfc_pkg::DIFF_W-1:0]         d_s2;
	logic signed [pfc_pkg::INTEGRAL_WIDTH-1:0] integ_s2;

	// s3
	logic signed [pfc_pkg::PROD_P_W-1:0] mul_p, prod_p_s3;
	logic signed [pfc_pkg::PROD_I_W-1:0] mul_i, prod_i_s3;
	logic signed [pfc_pkg::PROD_D_W-1:0] mul_d, prod_d_s3;
	logic signed [pfc_pkg::ERR_W-1:0]    e_s3;

	// s4
	logic signed [pfc_pkg::SUM_W-1:0]    sum_all;
	logic signed [pfc_pkg::SUM_W-1:0]    scaled;
	logic signed [pfc_pkg::SUM_W-1:0]    lim_pos;
	logic signed [pfc_pkg::SUM_W-1:0]    lim_neg;
	logic signed [pfc_pkg::DRIVE_W-1:0]  drive_c;
	logic                                clamp_c;
	logic signed [pfc_pkg::DRIVE_W-1:0]  drive_s4;
	logic signed [pfc_pkg::ERR_W-1:0]    e_s4;
	logic                                clamp_s4;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q <= pfc_pkg::RST_REFERENCE;
			gain_p_q    <= pfc_pkg::RST_GAIN_P;
			gain_i_q    <= pfc_pkg::RST_GAIN_I;
			gain_d_q    <= pfc_pkg::RST_GAIN_D;
			deadband_q  <= pfc_pkg::RST_DEADBAND;
			limit_q     <= pfc_pkg::RST_LIMIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pfc_pkg::CFG_REFERENCE: reference_q <= cfg_wdata[pfc_pkg::FREQ_W-1:0];
				pfc_pkg::CFG_GAIN_P:    gain_p_q    <= cfg_wdata[pfc_pkg::GAIN_W-1:0];
				pfc_pkg::CFG_GAIN_I:    gain_i_q    <= cfg_wdata[pfc_pkg::GAIN_W-1:0];
				pfc_pkg::CFG_GAIN_D:    gain_d_q    <= cfg_wdata[pfc_pkg::GAIN_W-1:0];
				pfc_pkg::CFG_DEADBAND:  deadband_q  <= cfg_wdata[pfc_pkg::FREQ_W-1:0];
				pfc_pkg::CFG_LIMIT:     limit_q     <= cfg_wdata[pfc_pkg::LIMIT_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// ---------------- flow control ----------------
	// a stage may load when it is empty or its contents move on this cycle
	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- s1: input register ----------------
	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			meas_s1 <= sample.measured_freq;
			clr_s1  <= sample.clear_integral;
		end
	end

	// ---------------- s2: error, deadband, integral ----------------
	// integral and previous error advance exactly when a sample enters s2
	assign step.load  = en2 && v_s1;
	assign step.clear = clr_s1;

	pfc_integrator u_integrator (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.meas      (meas_s1),
		.reference (reference_q),
		.deadband  (deadband_q),
		.e_s2      (e_s2),
		.d_s2      (d_s2),
		.integ_s2  (integ_s2)
	);

	// ---------------- s3: gain products ----------------
	// full-precision signed products, three independent multipliers
	assign mul_p = gain_p_q * e_s2;
	assign mul_i = gain_i_q * integ_s2;
	assign mul_d = gain_d_q * d_s2;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			prod_p_s3 <= mul_p;
			prod_i_s3 <= mul_i;
			prod_d_s3 <= mul_d;
			e_s3      <= e_s2;
		end
	end

	// ---------------- s4: sum, scale, clamp ----------------
	assign sum_all = {{(pfc_pkg::SUM_W - pfc_pkg::PROD_P_W){prod_p_s3[pfc_pkg::PROD_P_W-1]}},
			prod_p_s3}
		+ {{(pfc_pkg::SUM_W - pfc_pkg::PROD_I_W){prod_i_s3[pfc_pkg::PROD_I_W-1]}}, prod_i_s3}
		+ {{(pfc_pkg::SUM_W - pfc_pkg::PROD_D_W){prod_d_s3[pfc_pkg::PROD_D_W-1]}}, prod_d_s3};

	// arithmetic shift is floor division by 256: Q.24 back to Q.16
	assign scaled  = sum_all >>> pfc_pkg::DRIVE_SHIFT;
	assign lim_pos = $signed({{(pfc_pkg::SUM_W - pfc_pkg::LIMIT_W){1'b0}}, limit_q});
	assign lim_neg = -lim_pos;

	// a value exactly at the limit passes with the flag low
	always_comb begin
		if (scaled > lim_pos) begin
			drive_c = pfc_pkg::DRIVE_W'(lim_pos);
			clamp_c = 1'b1;
		end else if (scaled < lim_neg) begin
			drive_c = pfc_pkg::DRIVE_W'(lim_neg);
			clamp_c = 1'b1;
		end else begin
			drive_c = pfc_pkg::DRIVE_W'(scaled);
			clamp_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			drive_s4 <= drive_c;
			e_s4     <= e_s3;
			clamp_s4 <= clamp_c;
		end
	end

	assign result.valid       = v_s4;
	assign result.drive       = drive_s4;
	assign result.error_value = e_s4;
	assign result.clamped     = clamp_s4;

	`PFC_ASSERT_IMP(a_ready_full, !sample.ready, v_s1 && v_s2 && v_s3 && v_s4, "sample stalled with a bubble in the pipeline")
	`PFC_ASSERT_IMP(a_result_drop, $fell(v_s4), $past(result.ready), "result dropped without being taken")
	`PFC_ASSERT_IMP(a_integrator_step, step.load, v_s1 && en2, "integrator stepped without a sample moving into s2")

endmodule
